/* design/c6502_pkg.sv */
// ----------------------------------------------------------------------------
// c6502_pkg
// Shared types, opcode names, decode and ALU helpers for the 6502 core.
// ----------------------------------------------------------------------------
package c6502_pkg;

  localparam int MEM_AW = 16;
  localparam int MEM_DW = 8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] prog_counter;
    logic [7:0]  acc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_ptr;
    logic [7:0]  flags;
    logic        halted;
    logic        bad_opcode;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [MEM_DW-1:0] wdata;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;
  localparam logic [1:0] MODE_STEP  = 2'd3;

  localparam logic [15:0] RESET_VEC  = 16'hFFFC;
  localparam logic [7:0]  STACK_PAGE = 8'h01;
  localparam logic [7:0]  SP_INIT    = 8'hFD;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_U = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  // addressing modes
  localparam logic [3:0] AM_IMM = 4'd0;
  localparam logic [3:0] AM_ZP  = 4'd1;
  localparam logic [3:0] AM_ZPX = 4'd2;
  localparam logic [3:0] AM_ZPY = 4'd3;
  localparam logic [3:0] AM_ABS = 4'd4;
  localparam logic [3:0] AM_ABX = 4'd5;
  localparam logic [3:0] AM_ABY = 4'd6;
  localparam logic [3:0] AM_IZX = 4'd7;
  localparam logic [3:0] AM_IZY = 4'd8;

  // instruction classes
  localparam logic [3:0] CL_MEM    = 4'd0;
  localparam logic [3:0] CL_BRANCH = 4'd1;
  localparam logic [3:0] CL_JMP    = 4'd2;
  localparam logic [3:0] CL_JMPI   = 4'd3;
  localparam logic [3:0] CL_JSR    = 4'd4;
  localparam logic [3:0] CL_POP    = 4'd5;
  localparam logic [3:0] CL_IMPL   = 4'd6;
  localparam logic [3:0] CL_BRK    = 4'd7;
  localparam logic [3:0] CL_BAD    = 4'd8;

  // memory operand functions
  localparam logic [4:0] FN_ORA = 5'd0;
  localparam logic [4:0] FN_AND = 5'd1;
  localparam logic [4:0] FN_EOR = 5'd2;
  localparam logic [4:0] FN_ADC = 5'd3;
  localparam logic [4:0] FN_STA = 5'd4;
  localparam logic [4:0] FN_LDA = 5'd5;
  localparam logic [4:0] FN_CMP = 5'd6;
  localparam logic [4:0] FN_SBC = 5'd7;
  localparam logic [4:0] FN_ASL = 5'd8;
  localparam logic [4:0] FN_ROL = 5'd9;
  localparam logic [4:0] FN_LSR = 5'd10;
  localparam logic [4:0] FN_ROR = 5'd11;
  localparam logic [4:0] FN_DEC = 5'd12;
  localparam logic [4:0] FN_INC = 5'd13;
  localparam logic [4:0] FN_BIT = 5'd14;
  localparam logic [4:0] FN_LDX = 5'd15;
  localparam logic [4:0] FN_LDY = 5'd16;
  localparam logic [4:0] FN_STX = 5'd17;
  localparam logic [4:0] FN_STY = 5'd18;
  localparam logic [4:0] FN_CPX = 5'd19;
  localparam logic [4:0] FN_CPY = 5'd20;

  localparam logic [1:0] SH_ASL = 2'd0;
  localparam logic [1:0] SH_ROL = 2'd1;
  localparam logic [1:0] SH_LSR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // opcodes
  localparam logic [7:0] OP_BRK    = 8'h00;
  localparam logic [7:0] OP_PHP    = 8'h08;
  localparam logic [7:0] OP_CLC    = 8'h18;
  localparam logic [7:0] OP_JSR    = 8'h20;
  localparam logic [7:0] OP_BIT_Z  = 8'h24;
  localparam logic [7:0] OP_PLP    = 8'h28;
  localparam logic [7:0] OP_BIT_A  = 8'h2C;
  localparam logic [7:0] OP_SEC    = 8'h38;
  localparam logic [7:0] OP_RTI    = 8'h40;
  localparam logic [7:0] OP_PHA    = 8'h48;
  localparam logic [7:0] OP_JMP    = 8'h4C;
  localparam logic [7:0] OP_CLI    = 8'h58;
  localparam logic [7:0] OP_RTS    = 8'h60;
  localparam logic [7:0] OP_PLA    = 8'h68;
  localparam logic [7:0] OP_JMPI   = 8'h6C;
  localparam logic [7:0] OP_SEI    = 8'h78;
  localparam logic [7:0] OP_STY_Z  = 8'h84;
  localparam logic [7:0] OP_STX_Z  = 8'h86;
  localparam logic [7:0] OP_DEY    = 8'h88;
  localparam logic [7:0] OP_STA_I  = 8'h89;
  localparam logic [7:0] OP_TXA    = 8'h8A;
  localparam logic [7:0] OP_STY_A  = 8'h8C;
  localparam logic [7:0] OP_STX_A  = 8'h8E;
  localparam logic [7:0] OP_STY_ZX = 8'h94;
  localparam logic [7:0] OP_STX_ZY = 8'h96;
  localparam logic [7:0] OP_TYA    = 8'h98;
  localparam logic [7:0] OP_TXS    = 8'h9A;
  localparam logic [7:0] OP_LDY_I  = 8'hA0;
  localparam logic [7:0] OP_LDX_I  = 8'hA2;
  localparam logic [7:0] OP_LDY_Z  = 8'hA4;
  localparam logic [7:0] OP_LDX_Z  = 8'hA6;
  localparam logic [7:0] OP_TAY    = 8'hA8;
  localparam logic [7:0] OP_TAX    = 8'hAA;
  localparam logic [7:0] OP_LDY_A  = 8'hAC;
  localparam logic [7:0] OP_LDX_A  = 8'hAE;
  localparam logic [7:0] OP_LDY_ZX = 8'hB4;
  localparam logic [7:0] OP_LDX_ZY = 8'hB6;
  localparam logic [7:0] OP_CLV    = 8'hB8;
  localparam logic [7:0] OP_TSX    = 8'hBA;
  localparam logic [7:0] OP_LDY_AX = 8'hBC;
  localparam logic [7:0] OP_LDX_AY = 8'hBE;
  localparam logic [7:0] OP_CPY_I  = 8'hC0;
  localparam logic [7:0] OP_CPY_Z  = 8'hC4;
  localparam logic [7:0] OP_INY    = 8'hC8;
  localparam logic [7:0] OP_DEX    = 8'hCA;
  localparam logic [7:0] OP_CPY_A  = 8'hCC;
  localparam logic [7:0] OP_CLD    = 8'hD8;
  localparam logic [7:0] OP_CPX_I  = 8'hE0;
  localparam logic [7:0] OP_CPX_Z  = 8'hE4;
  localparam logic [7:0] OP_INX    = 8'hE8;
  localparam logic [7:0] OP_NOP    = 8'hEA;
  localparam logic [7:0] OP_CPX_A  = 8'hEC;
  localparam logic [7:0] OP_SED    = 8'hF8;

  typedef struct packed {
    logic [3:0] cls;
    logic [3:0] am;
    logic [4:0] fn;
  } dec_t;

  function automatic logic [3:0] alu_mode(input logic [2:0] sub);
    case (sub)
      3'd0:    return AM_IZX;
      3'd1:    return AM_ZP;
      3'd2:    return AM_IMM;
      3'd3:    return AM_ABS;
      3'd4:    return AM_IZY;
      3'd5:    return AM_ZPX;
      3'd6:    return AM_ABY;
      default: return AM_ABX;
    endcase
  endfunction

  function automatic logic [3:0] rmw_mode(input logic [2:0] sub);
    case (sub)
      3'd1:    return AM_ZP;
      3'd3:    return AM_ABS;
      3'd5:    return AM_ZPX;
      3'd7:    return AM_ABX;
      default: return AM_IMM;
    endcase
  endfunction

  function automatic dec_t mem_dec(input logic [3:0] am, input logic [4:0] fn);
    dec_t d;
    d.cls = CL_MEM;
    d.am  = am;
    d.fn  = fn;
    return d;
  endfunction

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    logic [2:0] grp;
    logic [2:0] sub;
    grp   = op[7:5];
    sub   = op[4:2];
    d.cls = CL_BAD;
    d.am  = AM_IMM;
    d.fn  = FN_ORA;
    if (op[1:0] == 2'b01 && op != OP_STA_I) begin
      d.cls = CL_MEM;
      d.am  = alu_mode(sub);
      case (grp)
        3'd0:    d.fn = FN_ORA;
        3'd1:    d.fn = FN_AND;
        3'd2:    d.fn = FN_EOR;
        3'd3:    d.fn = FN_ADC;
        3'd4:    d.fn = FN_STA;
        3'd5:    d.fn = FN_LDA;
        3'd6:    d.fn = FN_CMP;
        default: d.fn = FN_SBC;
      endcase
    end else if (op[1:0] == 2'b10 && !grp[2] && sub == 3'd2) begin
      d.cls = CL_IMPL;  // accumulator shift
    end else if (op[1:0] == 2'b10 && !grp[2] && sub[0]) begin
      d.cls = CL_MEM;
      d.am  = rmw_mode(sub);
      case (grp[1:0])
        2'd0:    d.fn = FN_ASL;
        2'd1:    d.fn = FN_ROL;
        2'd2:    d.fn = FN_LSR;
        default: d.fn = FN_ROR;
      endcase
    end else if (op[1:0] == 2'b10 && grp[2:1] == 2'b11 && sub[0]) begin
      d.cls = CL_MEM;
      d.am  = rmw_mode(sub);
      d.fn  = grp[0] ? FN_INC : FN_DEC;
    end else if (op[4:0] == 5'b10000) begin
      d.cls = CL_BRANCH;
    end else begin
      case (op)
        OP_BRK:    d.cls = CL_BRK;
        OP_JMP:    d.cls = CL_JMP;
        OP_JMPI:   d.cls = CL_JMPI;
        OP_JSR:    d.cls = CL_JSR;
        OP_PLA, OP_PLP, OP_RTS, OP_RTI: d.cls = CL_POP;
        OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED,
        OP_DEX, OP_DEY, OP_INX, OP_INY, OP_NOP, OP_PHA, OP_PHP,
        OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA: d.cls = CL_IMPL;
        OP_BIT_Z:  d = mem_dec(AM_ZP, FN_BIT);
        OP_BIT_A:  d = mem_dec(AM_ABS, FN_BIT);
        OP_CPX_I:  d = mem_dec(AM_IMM, FN_CPX);
        OP_CPX_Z:  d = mem_dec(AM_ZP, FN_CPX);
        OP_CPX_A:  d = mem_dec(AM_ABS, FN_CPX);
        OP_CPY_I:  d = mem_dec(AM_IMM, FN_CPY);
        OP_CPY_Z:  d = mem_dec(AM_ZP, FN_CPY);
        OP_CPY_A:  d = mem_dec(AM_ABS, FN_CPY);
        OP_LDX_I:  d = mem_dec(AM_IMM, FN_LDX);
        OP_LDX_Z:  d = mem_dec(AM_ZP, FN_LDX);
        OP_LDX_ZY: d = mem_dec(AM_ZPY, FN_LDX);
        OP_LDX_A:  d = mem_dec(AM_ABS, FN_LDX);
        OP_LDX_AY: d = mem_dec(AM_ABY, FN_LDX);
        OP_LDY_I:  d = mem_dec(AM_IMM, FN_LDY);
        OP_LDY_Z:  d = mem_dec(AM_ZP, FN_LDY);
        OP_LDY_ZX: d = mem_dec(AM_ZPX, FN_LDY);
        OP_LDY_A:  d = mem_dec(AM_ABS, FN_LDY);
        OP_LDY_AX: d = mem_dec(AM_ABX, FN_LDY);
        OP_STX_Z:  d = mem_dec(AM_ZP, FN_STX);
        OP_STX_ZY: d = mem_dec(AM_ZPY, FN_STX);
        OP_STX_A:  d = mem_dec(AM_ABS, FN_STX);
        OP_STY_Z:  d = mem_dec(AM_ZP, FN_STY);
        OP_STY_ZX: d = mem_dec(AM_ZPX, FN_STY);
        OP_STY_A:  d = mem_dec(AM_ABS, FN_STY);
        default:   d.cls = CL_BAD;
      endcase
    end
    return d;
  endfunction

  function automatic logic [7:0] set_zn(input logic [7:0] f, input logic [7:0] v);
    logic [7:0] r;
    r         = f;
    r[FLAG_Z] = (v == 8'h00);
    r[FLAG_N] = v[7];
    return r;
  endfunction

  // returns {flags, acc}
  function automatic logic [15:0] adc_op(input logic [7:0] f, input logic [7:0] a,
                                         input logic [7:0] v);
    logic [8:0] s;
    logic [7:0] r;
    s         = {1'b0, a} + {1'b0, v} + {8'h00, f[FLAG_C]};
    r         = set_zn(f, s[7:0]);
    r[FLAG_C] = s[8];
    r[FLAG_V] = ~(a[7] ^ v[7]) & (a[7] ^ s[7]);
    return {r, s[7:0]};
  endfunction

  function automatic logic [7:0] cmp_op(input logic [7:0] f, input logic [7:0] r,
                                        input logic [7:0] v);
    logic [7:0] o;
    o         = set_zn(f, r - v);
    o[FLAG_C] = (r >= v);
    return o;
  endfunction

  // returns {carry out, result}
  function automatic logic [8:0] shift_op(input logic [1:0] kind, input logic [7:0] v,
                                          input logic cin);
    case (kind)
      SH_ASL:  return {v[7], v[6:0], 1'b0};
      SH_ROL:  return {v[7], v[6:0], cin};
      SH_LSR:  return {v[0], 1'b0, v[7:1]};
      default: return {v[0], cin, v[7:1]};
    endcase
  endfunction

endpackage

/* design/cpu6502_instruction_core_unit.sv */
// ----------------------------------------------------------------------------
// cpu6502_instruction_core_unit
// 6502 core (binary arithmetic) with a 64 KiB memory and a step sequencer.
// ----------------------------------------------------------------------------
// One item is handled at a time. An instruction takes one step per dependent
// memory access (opcode, operand bytes, pointer bytes, data), plus one for
// the result. The sequencer walks a single 64 KiB RAM with a registered read
// port; that read port sets the rate. The result sits in an output register,
// so the next item can be taken while the previous result still waits.
module cpu6502_instruction_core_unit
  import c6502_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RDW   = 5'd1;
  localparam logic [4:0] S_RV0   = 5'd2;
  localparam logic [4:0] S_RV1   = 5'd3;
  localparam logic [4:0] S_DEC   = 5'd4;
  localparam logic [4:0] S_B     = 5'd5;
  localparam logic [4:0] S_HI    = 5'd6;
  localparam logic [4:0] S_PLO   = 5'd7;
  localparam logic [4:0] S_PHI   = 5'd8;
  localparam logic [4:0] S_RD    = 5'd9;
  localparam logic [4:0] S_EX    = 5'd10;
  localparam logic [4:0] S_JI0   = 5'd11;
  localparam logic [4:0] S_JI1   = 5'd12;
  localparam logic [4:0] S_JI2   = 5'd13;
  localparam logic [4:0] S_PSH_H = 5'd14;
  localparam logic [4:0] S_PSH_L = 5'd15;
  localparam logic [4:0] S_POPW  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]  state, state_next;
  logic [15:0] pc, pc_next;
  logic [7:0]  a, a_next, x, x_next, y, y_next, sp, sp_next, p, p_next;
  logic        halt, halt_next;
  logic [7:0]  op, op_next, lo, lo_next, ptr, ptr_next, rdata, rdata_next;
  logic [15:0] ea, ea_next;
  logic [1:0]  pcnt, pcnt_next;
  logic        bad, bad_next;
  dec_t        dreg, dreg_next;

  mem_req_t    mreq;
  logic [7:0]  mq;
  logic        done_take;

  c6502_mem u_mem (
    .clk (clk),
    .req (mreq),
    .q   (mq)
  );

  assign item_stall = (state != S_IDLE);
  assign done_take  = (state == S_DONE) && (!result_valid || !result_stall);

  always_comb begin
    dec_t        dn;
    logic [15:0] skip_pc;
    logic [15:0] ret;
    logic [15:0] tgt;
    logic [15:0] idx;
    logic [15:0] ad;
    logic [8:0]  sh;
    logic [7:0]  v;
    logic [7:0]  r;
    logic        flag;

    state_next = state;
    pc_next    = pc;
    a_next     = a;
    x_next     = x;
    y_next     = y;
    sp_next    = sp;
    p_next     = p;
    halt_next  = halt;
    op_next    = op;
    lo_next    = lo;
    ptr_next   = ptr;
    rdata_next = rdata;
    ea_next    = ea;
    pcnt_next  = pcnt;
    bad_next   = bad;
    dreg_next  = dreg;

    mreq.we    = 1'b0;
    mreq.waddr = ea;
    mreq.wdata = a;
    mreq.raddr = pc;

    dn      = decode(mq);
    v       = mq;
    ret     = pc + 16'd1;
    tgt     = {mq, lo};
    skip_pc = (dreg.am == AM_ABS || dreg.am == AM_ABX || dreg.am == AM_ABY) ?
              pc + 16'd2 : pc + 16'd1;
    idx     = (dreg.am == AM_ABX) ? {8'h00, x} :
              (dreg.am == AM_ABY || dreg.am == AM_IZY) ? {8'h00, y} : 16'h0000;
    sh      = 9'h000;
    r       = 8'h00;
    ad      = 16'h0000;
    flag    = 1'b0;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          rdata_next = 8'h00;
          bad_next   = 1'b0;
          case (item.mode)
            MODE_WRITE: begin
              mreq.we    = 1'b1;
              mreq.waddr = item.address;
              mreq.wdata = item.data;
              state_next = S_DONE;
            end
            MODE_READ: begin
              mreq.raddr = item.address;
              state_next = S_RDW;
            end
            MODE_RESET: begin
              mreq.raddr = RESET_VEC;
              state_next = S_RV0;
            end
            default: begin
              if (halt) begin
                state_next = S_DONE;
              end else begin
                mreq.raddr = pc;
                pc_next    = pc + 16'd1;
                state_next = S_DEC;
              end
            end
          endcase
        end
      end
      S_RDW: begin
        rdata_next = mq;
        state_next = S_DONE;
      end
      S_RV0: begin
        lo_next    = mq;
        mreq.raddr = RESET_VEC + 16'd1;
        state_next = S_RV1;
      end
      S_RV1: begin
        pc_next    = tgt;
        a_next     = 8'h00;
        x_next     = 8'h00;
        y_next     = 8'h00;
        p_next     = 8'h00;
        halt_next  = 1'b0;
        state_next = S_DONE;
      end
      S_DEC: begin
        op_next    = mq;
        dreg_next  = dn;
        mreq.raddr = pc;
        state_next = S_B;
        case (dn.cls)
          CL_BRK: begin
            halt_next  = 1'b1;
            state_next = S_DONE;
          end
          CL_BAD: begin
            halt_next  = 1'b1;
            bad_next   = 1'b1;
            state_next = S_DONE;
          end
          CL_POP: begin
            mreq.raddr = {STACK_PAGE, sp + 8'd1};
            sp_next    = sp + 8'd1;
            pcnt_next  = 2'd0;
            state_next = S_POPW;
          end
          CL_IMPL: begin
            state_next = S_DONE;
            case (mq)
              OP_CLC: p_next[FLAG_C] = 1'b0;
              OP_SEC: p_next[FLAG_C] = 1'b1;
              OP_CLI: p_next[FLAG_I] = 1'b0;
              OP_SEI: p_next[FLAG_I] = 1'b1;
              OP_CLV: p_next[FLAG_V] = 1'b0;
              OP_CLD: p_next[FLAG_D] = 1'b0;
              OP_SED: p_next[FLAG_D] = 1'b1;
              OP_DEX: begin
                x_next = x - 8'd1;
                p_next = set_zn(p, x - 8'd1);
              end
              OP_DEY: begin
                y_next = y - 8'd1;
                p_next = set_zn(p, y - 8'd1);
              end
              OP_INX: begin
                x_next = x + 8'd1;
                p_next = set_zn(p, x + 8'd1);
              end
              OP_INY: begin
                y_next = y + 8'd1;
                p_next = set_zn(p, y + 8'd1);
              end
              OP_NOP: ;
              OP_PHA: begin
                mreq.we    = 1'b1;
                mreq.waddr = {STACK_PAGE, sp};
                mreq.wdata = a;
                sp_next    = sp - 8'd1;
              end
              OP_PHP: begin
                mreq.we    = 1'b1;
                mreq.waddr = {STACK_PAGE, sp};
                mreq.wdata = p | 8'h30;
                sp_next    = sp - 8'd1;
              end
              OP_TAX: begin
                x_next = a;
                p_next = set_zn(p, a);
              end
              OP_TAY: begin
                y_next = a;
                p_next = set_zn(p, a);
              end
              OP_TSX: begin
                x_next = sp;
                p_next = set_zn(p, sp);
              end
              OP_TXA: begin
                a_next = x;
                p_next = set_zn(p, x);
              end
              OP_TXS: sp_next = x;
              OP_TYA: begin
                a_next = y;
                p_next = set_zn(p, y);
              end
              default: begin
                // accumulator shift: kind comes from opcode bits 6:5
                sh             = shift_op(mq[6:5], a, p[FLAG_C]);
                a_next         = sh[7:0];
                p_next         = set_zn(p, sh[7:0]);
                p_next[FLAG_C] = sh[8];
              end
            endcase
          end
          default: ;
        endcase
      end
      S_B: begin
        case (dreg.cls)
          CL_BRANCH: begin
            case (op[7:6])
              2'd0:    flag = p[FLAG_N];
              2'd1:    flag = p[FLAG_V];
              2'd2:    flag = p[FLAG_C];
              default: flag = p[FLAG_Z];
            endcase
            pc_next = (flag == op[5]) ? pc + 16'd1 + {{8{mq[7]}}, mq} : pc + 16'd1;
            state_next = S_DONE;
          end
          CL_MEM: begin
            state_next = S_RD;
            case (dreg.am)
              AM_IMM: ea_next = pc;
              AM_ZP:  ea_next = {8'h00, mq};
              AM_ZPX: ea_next = {8'h00, mq + x};
              AM_ZPY: ea_next = {8'h00, mq + y};
              AM_IZX: begin
                ptr_next   = mq + x;
                mreq.raddr = {8'h00, mq + x};
                state_next = S_PLO;
              end
              AM_IZY: begin
                ptr_next   = mq;
                mreq.raddr = {8'h00, mq};
                state_next = S_PLO;
              end
              default: begin
                lo_next    = mq;
                mreq.raddr = pc + 16'd1;
                state_next = S_HI;
              end
            endcase
          end
          default: begin
            lo_next    = mq;
            mreq.raddr = pc + 16'd1;
            state_next = S_HI;
          end
        endcase
      end
      S_HI: begin
        case (dreg.cls)
          CL_JMP: begin
            pc_next    = tgt;
            state_next = S_DONE;
          end
          CL_JMPI: begin
            ea_next    = tgt;
            state_next = S_JI0;
          end
          CL_JSR: begin
            ea_next    = tgt;
            state_next = S_PSH_H;
          end
          default: begin
            ea_next    = tgt + idx;
            state_next = S_RD;
          end
        endcase
      end
      S_JI0: begin
        mreq.raddr = ea;
        state_next = S_JI1;
      end
      S_JI1: begin
        // pointer high byte stays in the same page
        lo_next    = mq;
        mreq.raddr = {ea[15:8], ea[7:0] + 8'd1};
        state_next = S_JI2;
      end
      S_JI2: begin
        pc_next    = tgt;
        state_next = S_DONE;
      end
      S_PSH_H: begin
        mreq.we    = 1'b1;
        mreq.waddr = {STACK_PAGE, sp};
        mreq.wdata = ret[15:8];
        sp_next    = sp - 8'd1;
        state_next = S_PSH_L;
      end
      S_PSH_L: begin
        mreq.we    = 1'b1;
        mreq.waddr = {STACK_PAGE, sp};
        mreq.wdata = ret[7:0];
        sp_next    = sp - 8'd1;
        pc_next    = ea;
        state_next = S_DONE;
      end
      S_PLO: begin
        lo_next    = mq;
        mreq.raddr = {8'h00, ptr + 8'd1};
        state_next = S_PHI;
      end
      S_PHI: begin
        ea_next    = tgt + idx;
        state_next = S_RD;
      end
      S_RD: begin
        if (dreg.fn == FN_STA || dreg.fn == FN_STX || dreg.fn == FN_STY) begin
          mreq.we    = 1'b1;
          mreq.waddr = ea;
          mreq.wdata = (dreg.fn == FN_STX) ? x : (dreg.fn == FN_STY) ? y : a;
          pc_next    = skip_pc;
          state_next = S_DONE;
        end else begin
          mreq.raddr = ea;
          state_next = S_EX;
        end
      end
      S_EX: begin
        pc_next    = skip_pc;
        state_next = S_DONE;
        mreq.waddr = ea;
        case (dreg.fn)
          FN_ORA: begin
            a_next = a | v;
            p_next = set_zn(p, a | v);
          end
          FN_AND: begin
            a_next = a & v;
            p_next = set_zn(p, a & v);
          end
          FN_EOR: begin
            a_next = a ^ v;
            p_next = set_zn(p, a ^ v);
          end
          FN_LDA: begin
            a_next = v;
            p_next = set_zn(p, v);
          end
          FN_LDX: begin
            x_next = v;
            p_next = set_zn(p, v);
          end
          FN_LDY: begin
            y_next = v;
            p_next = set_zn(p, v);
          end
          FN_ADC: begin
            ad     = adc_op(p, a, v);
            p_next = ad[15:8];
            a_next = ad[7:0];
          end
          FN_SBC: begin
            ad     = adc_op(p, a, ~v);
            p_next = ad[15:8];
            a_next = ad[7:0];
          end
          FN_CMP: p_next = cmp_op(p, a, v);
          FN_CPX: p_next = cmp_op(p, x, v);
          FN_CPY: p_next = cmp_op(p, y, v);
          FN_BIT: begin
            p_next         = p;
            p_next[FLAG_Z] = ((a & v) == 8'h00);
            p_next[FLAG_N] = v[7];
            p_next[FLAG_V] = v[6];
          end
          FN_ASL, FN_ROL, FN_LSR, FN_ROR: begin
            case (dreg.fn)
              FN_ASL:  sh = shift_op(SH_ASL, v, p[FLAG_C]);
              FN_ROL:  sh = shift_op(SH_ROL, v, p[FLAG_C]);
              FN_LSR:  sh = shift_op(SH_LSR, v, p[FLAG_C]);
              default: sh = shift_op(SH_ROR, v, p[FLAG_C]);
            endcase
            mreq.we        = 1'b1;
            mreq.wdata     = sh[7:0];
            p_next         = set_zn(p, sh[7:0]);
            p_next[FLAG_C] = sh[8];
          end
          FN_DEC, FN_INC: begin
            r          = (dreg.fn == FN_DEC) ? v - 8'd1 : v + 8'd1;
            mreq.we    = 1'b1;
            mreq.wdata = r;
            p_next     = set_zn(p, r);
          end
          default: ;
        endcase
      end
      S_POPW: begin
        state_next = S_DONE;
        case (op)
          OP_PLA: begin
            a_next = v;
            p_next = set_zn(p, v);
          end
          OP_PLP: p_next = (v & 8'hEF) | 8'h20;
          OP_RTS: begin
            if (pcnt == 2'd0) begin
              lo_next    = v;
              mreq.raddr = {STACK_PAGE, sp + 8'd1};
              sp_next    = sp + 8'd1;
              pcnt_next  = pcnt + 2'd1;
              state_next = S_POPW;
            end else begin
              pc_next = tgt + 16'd1;
            end
          end
          default: begin
            // RTI: status, then return address low, high
            if (pcnt == 2'd2) begin
              pc_next = tgt;
            end else begin
              if (pcnt == 2'd0) begin
                p_next = (v & 8'hEF) | 8'h20;
              end else begin
                lo_next = v;
              end
              mreq.raddr = {STACK_PAGE, sp + 8'd1};
              sp_next    = sp + 8'd1;
              pcnt_next  = pcnt + 2'd1;
              state_next = S_POPW;
            end
          end
        endcase
      end
      S_DONE: begin
        if (done_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pc           <= 16'h0000;
      a            <= 8'h00;
      x            <= 8'h00;
      y            <= 8'h00;
      sp           <= SP_INIT;
      p            <= 8'h00;
      halt         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      a     <= a_next;
      x     <= x_next;
      y     <= y_next;
      sp    <= sp_next;
      p     <= p_next;
      halt  <= halt_next;
      if (done_take) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    lo    <= lo_next;
    ptr   <= ptr_next;
    ea    <= ea_next;
    pcnt  <= pcnt_next;
    rdata <= rdata_next;
    bad   <= bad_next;
    dreg  <= dreg_next;
    if (done_take) begin
      result.read_data    <= rdata;
      result.prog_counter <= pc;
      result.acc          <= a;
      result.index_x      <= x;
      result.index_y      <= y;
      result.stack_ptr    <= sp;
      result.flags        <= p;
      result.halted       <= halt;
      result.bad_opcode   <= bad;
    end
  end

`ifndef SYNTHESIS
  a_no_fetch_halted: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC) |-> !halt)
    else $error("instruction fetched while halted");

  a_bad_halts: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.bad_opcode) |-> result.halted)
    else $error("bad opcode reported without halt");

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result beat without a finished item");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (state == S_IDLE || state == S_DEC || state == S_RD || state == S_EX ||
                 state == S_PSH_H || state == S_PSH_L))
    else $error("memory write from unexpected state");
`endif

endmodule

/* design/c6502_mem.sv */
// ----------------------------------------------------------------------------
// c6502_mem
// 64 KiB byte RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module c6502_mem
  import c6502_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [MEM_DW-1:0] q
);

  logic [MEM_DW-1:0] mem [2**MEM_AW];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q <= mem[req.raddr];
  end

endmodule

/* dv/cpu6502_instruction_core_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu6502_instruction_core_unit_test
// Drives memory writes, reads, resets and instruction steps into the core and
// checks every result beat against an in-bench 6502 predictor. Programs grow
// on demand: before an item goes out, any byte it would read that was never
// written is first written with random content, biased toward real opcodes.
// ----------------------------------------------------------------------------
module cpu6502_instruction_core_unit_test;
  import c6502_pkg::*;

  typedef struct {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic        halt;
  } cpu_state_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  cpu6502_instruction_core_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // predictor state
  cpu_state_t  cpu;
  logic [7:0]  ram_img [0:65535];
  bit          ram_set [0:65535];
  bit          probing = 0;
  logic [15:0] missing_q[$];
  logic [15:0] undo_addr[$];
  logic [7:0]  undo_val[$];
  bit          undo_set[$];
  logic [15:0] known_addrs[$];

  item_t       pend_q[$];
  result_t     pend_exp[$];
  result_t     exp_q[$];
  int          fails = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          gap = 0;
  int          hold = 0;

  function automatic logic [7:0] peek(input logic [15:0] a);
    if (!ram_set[a]) begin
      if (probing) missing_q.push_back(a);
      return 8'h00;
    end
    return ram_img[a];
  endfunction

  function automatic void poke(input logic [15:0] a, input logic [7:0] v);
    if (probing) begin
      undo_addr.push_back(a);
      undo_val.push_back(ram_img[a]);
      undo_set.push_back(ram_set[a]);
    end
    ram_img[a] = v;
    ram_set[a] = 1'b1;
  endfunction

  function automatic void set_nz(input logic [7:0] v);
    cpu.p[FLAG_Z] = (v == 8'h00);
    cpu.p[FLAG_N] = v[7];
  endfunction

  function automatic void add_with_carry(input logic [7:0] v);
    logic [8:0] s;
    s = {1'b0, cpu.a} + {1'b0, v} + {8'h00, cpu.p[FLAG_C]};
    cpu.p[FLAG_C] = s[8];
    cpu.p[FLAG_V] = ~(cpu.a[7] ^ v[7]) & (cpu.a[7] ^ s[7]);
    cpu.a = s[7:0];
    set_nz(cpu.a);
  endfunction

  function automatic void compare_to(input logic [7:0] r, input logic [7:0] v);
    cpu.p[FLAG_C] = (r >= v);
    set_nz(r - v);
  endfunction

  function automatic logic [7:0] shift_rot(input logic [1:0] kind, input logic [7:0] v);
    logic [7:0] r;
    logic       cin;
    cin = cpu.p[FLAG_C];
    case (kind)
      SH_ASL:  begin cpu.p[FLAG_C] = v[7]; r = {v[6:0], 1'b0}; end
      SH_ROL:  begin cpu.p[FLAG_C] = v[7]; r = {v[6:0], cin}; end
      SH_LSR:  begin cpu.p[FLAG_C] = v[0]; r = {1'b0, v[7:1]}; end
      default: begin cpu.p[FLAG_C] = v[0]; r = {cin, v[7:1]}; end
    endcase
    set_nz(r);
    return r;
  endfunction

  function automatic logic [3:0] group_one_am(input logic [2:0] s);
    case (s)
      3'd0:    return AM_IZX;
      3'd1:    return AM_ZP;
      3'd2:    return AM_IMM;
      3'd3:    return AM_ABS;
      3'd4:    return AM_IZY;
      3'd5:    return AM_ZPX;
      3'd6:    return AM_ABY;
      default: return AM_ABX;
    endcase
  endfunction

  function automatic logic [3:0] rmw_am(input logic [2:0] s);
    case (s)
      3'd1:    return AM_ZP;
      3'd3:    return AM_ABS;
      3'd5:    return AM_ZPX;
      3'd7:    return AM_ABX;
      default: return AM_IMM;
    endcase
  endfunction

  // operand bytes are both fetched whatever the mode, as the core may do
  function automatic logic [15:0] eff_addr(input logic [3:0] m);
    logic [7:0]  b;
    logic [7:0]  t;
    logic [7:0]  t1;
    logic [15:0] w;
    b = peek(cpu.pc);
    w = {peek(cpu.pc + 16'd1), b};
    case (m)
      AM_ZP:  return {8'h00, b};
      AM_ZPX: begin t = b + cpu.x; return {8'h00, t}; end
      AM_ZPY: begin t = b + cpu.y; return {8'h00, t}; end
      AM_ABS: return w;
      AM_ABX: return w + {8'h00, cpu.x};
      AM_ABY: return w + {8'h00, cpu.y};
      AM_IZX: begin
        t  = b + cpu.x;
        t1 = t + 8'd1;
        return {peek({8'h00, t1}), peek({8'h00, t})};
      end
      AM_IZY: begin
        t1 = b + 8'd1;
        return {peek({8'h00, t1}), peek({8'h00, b})} + {8'h00, cpu.y};
      end
      default: return cpu.pc;
    endcase
  endfunction

  function automatic void step_past(input logic [3:0] m);
    cpu.pc = cpu.pc + ((m == AM_ABS || m == AM_ABX || m == AM_ABY) ? 16'd2 : 16'd1);
  endfunction

  function automatic void pushb(input logic [7:0] v);
    poke({STACK_PAGE, cpu.sp}, v);
    cpu.sp = cpu.sp - 8'd1;
  endfunction

  function automatic logic [7:0] popb();
    cpu.sp = cpu.sp + 8'd1;
    return peek({STACK_PAGE, cpu.sp});
  endfunction

  function automatic logic [7:0] load_from(input logic [3:0] m);
    logic [7:0] v;
    v = peek(eff_addr(m));
    set_nz(v);
    step_past(m);
    return v;
  endfunction

  function automatic void store_to(input logic [7:0] v, input logic [3:0] m);
    poke(eff_addr(m), v);
    step_past(m);
  endfunction

  function automatic void compare_mem(input logic [7:0] r, input logic [3:0] m);
    compare_to(r, peek(eff_addr(m)));
    step_past(m);
  endfunction

  // one instruction; returns 1 on an unimplemented opcode
  function automatic bit run_instr();
    logic [7:0]  op;
    logic [2:0]  grp;
    logic [2:0]  sub;
    logic [3:0]  m;
    logic [15:0] ad;
    logic [7:0]  v;
    logic [7:0]  lo;
    logic        fl;
    op  = peek(cpu.pc);
    grp = op[7:5];
    sub = op[4:2];
    cpu.pc = cpu.pc + 16'd1;
    if (op[1:0] == 2'b01 && op != OP_STA_I) begin
      m  = group_one_am(sub);
      ad = eff_addr(m);
      v  = peek(ad);
      case (grp)
        3'd0: begin cpu.a = cpu.a | v; set_nz(cpu.a); end
        3'd1: begin cpu.a = cpu.a & v; set_nz(cpu.a); end
        3'd2: begin cpu.a = cpu.a ^ v; set_nz(cpu.a); end
        3'd3: add_with_carry(v);
        3'd4: poke(ad, cpu.a);
        3'd5: begin cpu.a = v; set_nz(cpu.a); end
        3'd6: compare_to(cpu.a, v);
        default: add_with_carry(~v);
      endcase
      step_past(m);
      return 0;
    end
    if (op[1:0] == 2'b10 && grp <= 3'd3 && (sub[0] || sub == 3'd2)) begin
      if (sub == 3'd2) begin
        cpu.a = shift_rot(grp[1:0], cpu.a);
        return 0;
      end
      m  = rmw_am(sub);
      ad = eff_addr(m);
      poke(ad, shift_rot(grp[1:0], peek(ad)));
      step_past(m);
      return 0;
    end
    if (op[1:0] == 2'b10 && grp >= 3'd6 && sub[0]) begin
      m  = rmw_am(sub);
      ad = eff_addr(m);
      v  = (grp == 3'd6) ? peek(ad) - 8'd1 : peek(ad) + 8'd1;
      poke(ad, v);
      set_nz(v);
      step_past(m);
      return 0;
    end
    if (op[4:0] == 5'b10000) begin
      case (op[7:6])
        2'd0:    fl = cpu.p[FLAG_N];
        2'd1:    fl = cpu.p[FLAG_V];
        2'd2:    fl = cpu.p[FLAG_C];
        default: fl = cpu.p[FLAG_Z];
      endcase
      v = peek(cpu.pc);
      cpu.pc = cpu.pc + 16'd1;
      if (fl == op[5]) cpu.pc = cpu.pc + {{8{v[7]}}, v};
      return 0;
    end
    case (op)
      OP_BRK:   cpu.halt = 1'b1;
      OP_CLC:   cpu.p[FLAG_C] = 1'b0;
      OP_SEC:   cpu.p[FLAG_C] = 1'b1;
      OP_CLI:   cpu.p[FLAG_I] = 1'b0;
      OP_SEI:   cpu.p[FLAG_I] = 1'b1;
      OP_CLV:   cpu.p[FLAG_V] = 1'b0;
      OP_CLD:   cpu.p[FLAG_D] = 1'b0;
      OP_SED:   cpu.p[FLAG_D] = 1'b1;
      OP_BIT_Z, OP_BIT_A: begin
        m = (op == OP_BIT_Z) ? AM_ZP : AM_ABS;
        v = peek(eff_addr(m));
        cpu.p[FLAG_Z] = ((cpu.a & v) == 8'h00);
        cpu.p[FLAG_N] = v[7];
        cpu.p[FLAG_V] = v[6];
        step_past(m);
      end
      OP_CPX_I: compare_mem(cpu.x, AM_IMM);
      OP_CPX_Z: compare_mem(cpu.x, AM_ZP);
      OP_CPX_A: compare_mem(cpu.x, AM_ABS);
      OP_CPY_I: compare_mem(cpu.y, AM_IMM);
      OP_CPY_Z: compare_mem(cpu.y, AM_ZP);
      OP_CPY_A: compare_mem(cpu.y, AM_ABS);
      OP_DEX:   begin cpu.x = cpu.x - 8'd1; set_nz(cpu.x); end
      OP_DEY:   begin cpu.y = cpu.y - 8'd1; set_nz(cpu.y); end
      OP_INX:   begin cpu.x = cpu.x + 8'd1; set_nz(cpu.x); end
      OP_INY:   begin cpu.y = cpu.y + 8'd1; set_nz(cpu.y); end
      OP_NOP:   ;
      OP_JMP:   cpu.pc = {peek(cpu.pc + 16'd1), peek(cpu.pc)};
      OP_JMPI: begin
        ad = {peek(cpu.pc + 16'd1), peek(cpu.pc)};
        // pointer high byte comes from the same page
        cpu.pc = {peek({ad[15:8], ad[7:0] + 8'd1}), peek(ad)};
      end
      OP_JSR: begin
        ad = cpu.pc + 16'd1;
        pushb(ad[15:8]);
        pushb(ad[7:0]);
        cpu.pc = {peek(cpu.pc + 16'd1), peek(cpu.pc)};
      end
      OP_RTS: begin
        lo = popb();
        cpu.pc = {popb(), lo} + 16'd1;
      end
      OP_RTI: begin
        cpu.p = popb();
        cpu.p[FLAG_B] = 1'b0;
        cpu.p[FLAG_U] = 1'b1;
        lo = popb();
        cpu.pc = {popb(), lo};
      end
      OP_LDX_I:  cpu.x = load_from(AM_IMM);
      OP_LDX_Z:  cpu.x = load_from(AM_ZP);
      OP_LDX_ZY: cpu.x = load_from(AM_ZPY);
      OP_LDX_A:  cpu.x = load_from(AM_ABS);
      OP_LDX_AY: cpu.x = load_from(AM_ABY);
      OP_LDY_I:  cpu.y = load_from(AM_IMM);
      OP_LDY_Z:  cpu.y = load_from(AM_ZP);
      OP_LDY_ZX: cpu.y = load_from(AM_ZPX);
      OP_LDY_A:  cpu.y = load_from(AM_ABS);
      OP_LDY_AX: cpu.y = load_from(AM_ABX);
      OP_STX_Z:  store_to(cpu.x, AM_ZP);
      OP_STX_ZY: store_to(cpu.x, AM_ZPY);
      OP_STX_A:  store_to(cpu.x, AM_ABS);
      OP_STY_Z:  store_to(cpu.y, AM_ZP);
      OP_STY_ZX: store_to(cpu.y, AM_ZPX);
      OP_STY_A:  store_to(cpu.y, AM_ABS);
      OP_PHA:    pushb(cpu.a);
      OP_PHP:    pushb(cpu.p | 8'h30);
      OP_PLA:    begin cpu.a = popb(); set_nz(cpu.a); end
      OP_PLP: begin
        cpu.p = popb();
        cpu.p[FLAG_B] = 1'b0;
        cpu.p[FLAG_U] = 1'b1;
      end
      OP_TAX:    begin cpu.x = cpu.a; set_nz(cpu.x); end
      OP_TAY:    begin cpu.y = cpu.a; set_nz(cpu.y); end
      OP_TSX:    begin cpu.x = cpu.sp; set_nz(cpu.x); end
      OP_TXA:    begin cpu.a = cpu.x; set_nz(cpu.a); end
      OP_TXS:    cpu.sp = cpu.x;
      OP_TYA:    begin cpu.a = cpu.y; set_nz(cpu.a); end
      default: begin
        cpu.halt = 1'b1;
        return 1;
      end
    endcase
    return 0;
  endfunction

  function automatic result_t run_item(input item_t it);
    result_t r;
    r = '0;
    case (it.mode)
      MODE_WRITE: poke(it.address, it.data);
      MODE_READ:  r.read_data = peek(it.address);
      MODE_RESET: begin
        cpu.a = 8'h00;
        cpu.x = 8'h00;
        cpu.y = 8'h00;
        cpu.p = 8'h00;
        cpu.halt = 1'b0;
        cpu.pc = {peek(RESET_VEC + 16'd1), peek(RESET_VEC)};
      end
      default: if (!cpu.halt) r.bad_opcode = run_instr();
    endcase
    r.prog_counter = cpu.pc;
    r.acc          = cpu.a;
    r.index_x      = cpu.x;
    r.index_y      = cpu.y;
    r.stack_ptr    = cpu.sp;
    r.flags        = cpu.p;
    r.halted       = cpu.halt;
    return r;
  endfunction

  function automatic bit is_official(input logic [7:0] op);
    if (op[1:0] == 2'b01) return op != OP_STA_I;
    if (op[1:0] == 2'b10 && op[7:5] <= 3'd3 && (op[2] || op[4:2] == 3'd2)) return 1;
    if (op[1:0] == 2'b10 && op[7:6] == 2'b11 && op[2]) return 1;
    if (op[4:0] == 5'b10000) return 1;
    return op inside {OP_BRK, OP_PHP, OP_CLC, OP_JSR, OP_BIT_Z, OP_PLP, OP_BIT_A, OP_SEC,
                      OP_RTI, OP_PHA, OP_JMP, OP_CLI, OP_RTS, OP_PLA, OP_JMPI, OP_SEI,
                      OP_STY_Z, OP_STX_Z, OP_DEY, OP_TXA, OP_STY_A, OP_STX_A, OP_STY_ZX,
                      OP_STX_ZY, OP_TYA, OP_TXS, OP_LDY_I, OP_LDX_I, OP_LDY_Z, OP_LDX_Z,
                      OP_TAY, OP_TAX, OP_LDY_A, OP_LDX_A, OP_LDY_ZX, OP_LDX_ZY, OP_CLV,
                      OP_TSX, OP_LDY_AX, OP_LDX_AY, OP_CPY_I, OP_CPY_Z, OP_INY, OP_DEX,
                      OP_CPY_A, OP_CLD, OP_CPX_I, OP_CPX_Z, OP_INX, OP_NOP, OP_CPX_A,
                      OP_SED};
  endfunction

  function automatic logic [7:0] fill_byte(input bit opcode_slot);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < (opcode_slot ? 90 : 50))
      while (!is_official(v)) v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic void queue_item(input logic [1:0] mode, input logic [15:0] addr,
                                     input logic [7:0] data);
    item_t it;
    it.mode    = mode;
    it.address = addr;
    it.data    = data;
    pend_exp.push_back(run_item(it));
    pend_q.push_back(it);
    if (mode == MODE_WRITE) known_addrs.push_back(addr);
  endfunction

  // dry-run the item, write every never-written byte it reads, repeat
  function automatic void issue(input logic [1:0] mode, input logic [15:0] addr,
                                input logic [7:0] data);
    item_t      it;
    cpu_state_t saved;
    result_t    junk;
    it.mode    = mode;
    it.address = addr;
    it.data    = data;
    for (int pass = 0; pass < 32; pass++) begin
      saved = cpu;
      missing_q.delete();
      probing = 1;
      junk = run_item(it);
      probing = 0;
      cpu = saved;
      while (undo_addr.size() != 0) begin
        ram_img[undo_addr[$]] = undo_val[$];
        ram_set[undo_addr[$]] = undo_set[$];
        void'(undo_addr.pop_back());
        void'(undo_val.pop_back());
        void'(undo_set.pop_back());
      end
      if (missing_q.size() == 0) break;
      foreach (missing_q[k])
        if (!ram_set[missing_q[k]])
          queue_item(MODE_WRITE, missing_q[k],
                     fill_byte(mode == MODE_STEP && missing_q[k] == saved.pc));
    end
    queue_item(mode, addr, data);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        exp_q.push_back(pend_exp.pop_front());
        void'(pend_q.pop_front());
        n_in++;
        gap = (n_in % 120 < 30) ? 0 : $urandom_range(0, 19);
      end
      if (item_valid && item_stall) begin
        // stalled beat holds
      end else if (gap != 0) begin
        gap--;
        item_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        item_valid <= 1'b1;
        item       <= pend_q[0];
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (exp_q.size() == 0) begin
          fails++;
          $display("%0t unexpected result beat %h", $time, result);
        end else begin
          result_t e;
          e = exp_q.pop_front();
          check_field("read_data", 16'(e.read_data), 16'(result.read_data));
          check_field("prog_counter", e.prog_counter, result.prog_counter);
          check_field("acc", 16'(e.acc), 16'(result.acc));
          check_field("index_x", 16'(e.index_x), 16'(result.index_x));
          check_field("index_y", 16'(e.index_y), 16'(result.index_y));
          check_field("stack_ptr", 16'(e.stack_ptr), 16'(result.stack_ptr));
          check_field("flags", 16'(e.flags), 16'(result.flags));
          check_field("halted", 16'(e.halted), 16'(result.halted));
          check_field("bad_opcode", 16'(e.bad_opcode), 16'(result.bad_opcode));
        end
        n_out++;
        if (n_out == 60) hold = 400;  // long hold-off so the core backs up
        else if (n_out % 100 < 30) hold = 0;
        else hold = $urandom_range(0, 19);
      end else if (hold != 0) begin
        hold--;
      end
      result_stall <= (hold != 0);
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [7:0] prog [11];
    int         r;
    cpu = '{pc: 16'h0000, a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_INIT, p: 8'h00, halt: 1'b0};
    foreach (ram_set[i]) ram_set[i] = 0;

    // directed: memory extremes, reset, ADC overflow, accumulator shifts,
    // BIT, indirect JMP across a page end, BRK, halted step, bad opcode
    queue_item(MODE_WRITE, 16'h0000, 8'h00);
    queue_item(MODE_WRITE, 16'hFFFF, 8'hFF);
    queue_item(MODE_READ, 16'h0000, 8'h00);
    queue_item(MODE_READ, 16'hFFFF, 8'h00);
    queue_item(MODE_WRITE, RESET_VEC, 8'h00);
    queue_item(MODE_WRITE, RESET_VEC + 16'd1, 8'h02);
    issue(MODE_RESET, 16'h0000, 8'h00);
    prog = '{8'hA9, 8'h7F, 8'h69, 8'h01, 8'h4A, 8'h0A, 8'h24, 8'hFF, 8'h6C, 8'hFF, 8'h10};
    foreach (prog[i]) queue_item(MODE_WRITE, 16'h0200 + 16'(i), prog[i]);
    repeat (6) issue(MODE_STEP, 16'h0000, 8'h00);
    queue_item(MODE_WRITE, cpu.pc, OP_BRK);
    issue(MODE_STEP, 16'h0000, 8'h00);
    issue(MODE_STEP, 16'h0000, 8'h00);
    queue_item(MODE_WRITE, RESET_VEC + 16'd1, 8'h03);
    queue_item(MODE_WRITE, 16'h0300, 8'h02);
    issue(MODE_RESET, 16'h0000, 8'h00);
    issue(MODE_STEP, 16'h0000, 8'h00);

    while (pend_q.size() < 420) begin
      r = $urandom_range(0, 99);
      if ((cpu.halt && r < 70) || r < 2) begin
        if ($urandom_range(0, 2) == 0) begin
          queue_item(MODE_WRITE, RESET_VEC, 8'($urandom_range(0, 255)));
          queue_item(MODE_WRITE, RESET_VEC + 16'd1,
                     ($urandom_range(0, 9) < 7) ? 8'h02 : 8'($urandom_range(0, 255)));
        end
        issue(MODE_RESET, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end else if (r < 7) begin
        queue_item(MODE_READ, known_addrs[$urandom_range(0, known_addrs.size() - 1)],
                   8'($urandom_range(0, 255)));
      end else if (r < 12) begin
        queue_item(MODE_WRITE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end else begin
        issue(MODE_STEP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pend_q.size() == 0 && exp_q.size() == 0);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
